// ===== hw/rtl/pdeq_pkg.sv =====
// shared types, constants and helper functions for the priority device event queues
package pdeq_pkg;

    localparam int NUM_DEVICES = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int FLAG_BITS   = 8;
    localparam int TICK_W      = 32;
    localparam int DEV_NUM_W   = 3;

    localparam int DEV_W  = $clog2(NUM_DEVICES);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ADDR_W = $clog2(NUM_DEVICES * QUEUE_DEPTH);
    localparam int SLOT_MAX = QUEUE_DEPTH - 1;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] tag;
        logic [TICK_W-1:0] etime;
    } entry_t;

    // one queue update per transaction
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [DEV_W-1:0] dev;
        entry_t           entry;
    } q_upd_t;

    typedef struct packed {
        logic [NUM_DEVICES-1:0] nonempty;
        logic [NUM_DEVICES-1:0] full;
    } q_stat_t;

    typedef struct packed {
        logic             found;
        logic [DEV_W-1:0] idx;
    } pick_t;

    // lowest set bit wins
    function automatic pick_t pick_lowest(input logic [NUM_DEVICES-1:0] mask);
        pick_t p;
        p = '0;
        for (int d = NUM_DEVICES - 1; d >= 0; d--) begin
            if (mask[d]) begin
                p.found = 1'b1;
                p.idx   = DEV_W'(d);
            end
        end
        return p;
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_MAX)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [DEV_W-1:0] dev,
                                                     input logic [SLOT_W-1:0] slot);
        return ADDR_W'(32'(dev) * QUEUE_DEPTH + 32'(slot));
    endfunction

endpackage

// ===== hw/rtl/pdeq_queues.sv =====
// per-device circular event queues: entry store, fill counts and slot pointers
module pdeq_queues
    import pdeq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  q_upd_t           upd,
    input  logic [DEV_W-1:0] rd_dev,
    output q_stat_t          stat,
    output entry_t           head
);

    entry_t              store_reg      [NUM_DEVICES*QUEUE_DEPTH];
    logic [FILL_W-1:0]   fill_reg       [NUM_DEVICES];
    logic [SLOT_W-1:0]   write_slot_reg [NUM_DEVICES];
    logic [SLOT_W-1:0]   read_slot_reg  [NUM_DEVICES];

    always_comb begin
        for (int d = 0; d < NUM_DEVICES; d++) begin
            stat.nonempty[d] = (fill_reg[d] != '0);
            stat.full[d]     = (fill_reg[d] == FILL_W'(QUEUE_DEPTH));
        end
    end

    assign head = store_reg[store_addr(rd_dev, read_slot_reg[rd_dev])];

    // entry store, no reset
    always_ff @(posedge aclk) begin
        if (upd.wr_en) begin
            store_reg[store_addr(upd.dev, write_slot_reg[upd.dev])] <= upd.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < NUM_DEVICES; d++) begin
                fill_reg[d]       <= '0;
                write_slot_reg[d] <= '0;
                read_slot_reg[d]  <= '0;
            end
        end else if (upd.wr_en) begin
            fill_reg[upd.dev]       <= fill_reg[upd.dev] + FILL_W'(1);
            write_slot_reg[upd.dev] <= next_slot(write_slot_reg[upd.dev]);
        end else if (upd.rd_en) begin
            fill_reg[upd.dev]      <= fill_reg[upd.dev] - FILL_W'(1);
            read_slot_reg[upd.dev] <= next_slot(read_slot_reg[upd.dev]);
        end
    end

endmodule

// ===== hw/rtl/priority_device_event_queues_core.sv =====
// top level of the strict-priority per-device event queue scheduler
// flow: an accepted transaction waits in the input register until the compute stage fires into the result register
// throughput: one transaction per cycle while the result side does not stall, the queue state is
// read and updated in the compute stage between the input register and the result register
// reset: aresetn low empties every queue and clears both valid flags, stored
// entries keep their contents and are never read before being written
module priority_device_event_queues_core
    import pdeq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [FLAG_BITS-1:0]  s_pending_flags,
    input  logic [TICK_W-1:0]     s_event_tag,
    input  logic [TICK_W-1:0]     s_event_time,
    input  logic [TICK_W-1:0]     s_now_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DEV_NUM_W-1:0]  m_device_num,
    output logic                  m_acted,
    output logic                  m_dropped,
    output logic [FLAG_BITS-1:0]  m_remaining_flags,
    output logic [TICK_W-1:0]     m_served_tag,
    output logic [TICK_W-1:0]     m_served_time,
    output logic [TICK_W-1:0]     m_latency
);

    // input register stage
    logic                 in_valid_reg;
    logic                 cmd_reg;
    logic [FLAG_BITS-1:0] flags_reg;
    logic [TICK_W-1:0]    tag_reg;
    logic [TICK_W-1:0]    etime_reg;
    logic [TICK_W-1:0]    now_reg;

    // result register stage
    logic                 out_valid_reg;
    logic [DEV_NUM_W-1:0] dev_num_reg;
    logic                 acted_reg;
    logic                 dropped_reg;
    logic [FLAG_BITS-1:0] remaining_reg;
    logic [TICK_W-1:0]    served_tag_reg;
    logic [TICK_W-1:0]    served_time_reg;
    logic [TICK_W-1:0]    latency_reg;

    // compute stage
    logic                   fire;
    logic [NUM_DEVICES-1:0] enq_mask;
    pick_t                  enq_pick;
    pick_t                  deq_pick;
    q_upd_t                 upd;
    q_stat_t                stat;
    entry_t                 head;

    logic [DEV_W-1:0]     dev_next;
    logic                 acted_next;
    logic                 dropped_next;
    logic [FLAG_BITS-1:0] remaining_next;
    logic [TICK_W-1:0]    served_tag_next;
    logic [TICK_W-1:0]    served_time_next;
    logic [TICK_W-1:0]    latency_next;

    // the compute stage advances whenever the result register is free or drains
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    // flags above the device count are ignored, missing high devices read as zero
    assign enq_mask = NUM_DEVICES'(flags_reg);
    assign enq_pick = pick_lowest(enq_mask);
    assign deq_pick = pick_lowest(stat.nonempty);

    pdeq_queues u_queues (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .rd_dev  (deq_pick.idx),
        .stat    (stat),
        .head    (head)
    );

    always_comb begin
        dev_next         = '0;
        acted_next       = 1'b0;
        dropped_next     = 1'b0;
        remaining_next   = '0;
        served_tag_next  = '0;
        served_time_next = '0;
        latency_next     = '0;
        upd              = '0;
        upd.entry.tag    = tag_reg;
        upd.entry.etime  = etime_reg;

        case (cmd_reg)
            CMD_ENQUEUE: begin
                remaining_next = flags_reg;
                if (enq_pick.found) begin
                    acted_next     = 1'b1;
                    dev_next       = enq_pick.idx;
                    dropped_next   = stat.full[enq_pick.idx];
                    remaining_next = flags_reg & ~(FLAG_BITS'(1) << enq_pick.idx);
                    latency_next   = now_reg - etime_reg;
                    // a full queue drops the event and stays as it is
                    upd.wr_en      = fire && !stat.full[enq_pick.idx];
                    upd.dev        = enq_pick.idx;
                end
            end
            CMD_DEQUEUE: begin
                if (deq_pick.found) begin
                    acted_next       = 1'b1;
                    dev_next         = deq_pick.idx;
                    served_tag_next  = head.tag;
                    served_time_next = head.etime;
                    latency_next     = now_reg - head.etime;
                    upd.rd_en        = fire;
                    upd.dev          = deq_pick.idx;
                end
            end
            default: begin
                remaining_next = '0;
            end
        endcase
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            flags_reg <= s_pending_flags;
            tag_reg   <= s_event_tag;
            etime_reg <= s_event_time;
            now_reg   <= s_now_time;
        end
        if (fire) begin
            dev_num_reg     <= DEV_NUM_W'(dev_next);
            acted_reg       <= acted_next;
            dropped_reg     <= dropped_next;
            remaining_reg   <= remaining_next;
            served_tag_reg  <= served_tag_next;
            served_time_reg <= served_time_next;
            latency_reg     <= latency_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_device_num      = dev_num_reg;
    assign m_acted           = acted_reg;
    assign m_dropped         = dropped_reg;
    assign m_remaining_flags = remaining_reg;
    assign m_served_tag      = served_tag_reg;
    assign m_served_time     = served_time_reg;
    assign m_latency         = latency_reg;

endmodule

// ===== hw/rtl/pdeq_checker.sv =====
// port-level assertions for the priority device event queues, bound to the top level
module pdeq_checker
    import pdeq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [DEV_NUM_W-1:0] m_device_num,
    input logic                 m_acted,
    input logic                 m_dropped,
    input logic [FLAG_BITS-1:0] m_remaining_flags,
    input logic [TICK_W-1:0]    m_served_tag,
    input logic [TICK_W-1:0]    m_served_time,
    input logic [TICK_W-1:0]    m_latency
);

    // a drop only happens on a selected device
    a_drop_needs_act: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> m_acted)
        else $error("dropped without a selected device");

    // no selected device gives zero device, latency and served fields
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_acted |-> m_device_num == '0 && m_latency == '0
                                && m_served_tag == '0 && m_served_time == '0)
        else $error("idle result carries nonzero fields");

    // a dropped enqueue clears its device flag and serves nothing
    a_drop_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> !m_remaining_flags[m_device_num]
                                 && m_served_tag == '0 && m_served_time == '0)
        else $error("dropped result fields wrong");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_latency) && $stable(m_device_num))
        else $error("result changed while stalled");

endmodule

bind priority_device_event_queues_core pdeq_checker u_pdeq_checker (.*);
